// File: rtl/core/uap_pkg.sv
// Shared types, constants and character-class functions for the URL authority parser.
// No dependencies; every other file of the block depends on this package.
package uap_pkg;

  localparam int unsigned CapWidth  = 9;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned PortWidth = 16;

  // Largest usable host buffer, terminator included.
  localparam logic [CapWidth-1:0] MaxHost = 9'd256;
  localparam logic [CapWidth-1:0] CapReset = 9'd256;
  localparam logic [PortWidth-1:0] PortMax = 16'd65535;

  localparam logic [7:0] ChAt     = 8'h40;  // '@'
  localparam logic [7:0] ChLBrack = 8'h5B;  // '['
  localparam logic [7:0] ChRBrack = 8'h5D;  // ']'
  localparam logic [7:0] ChColon  = 8'h3A;  // ':'
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChZero   = 8'h30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       last_byte;
  } auth_item_t;

  typedef struct packed {
    logic [7:0]           host_byte;
    logic                 host_byte_valid;
    logic                 final_result;
    logic                 status;
    logic [CountWidth-1:0] host_length;
    logic [PortWidth-1:0] port_value;
    logic                 port_present;
  } auth_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_reg_byte(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           is_digit(c) || (c == ChDash) || (c == ChDot) || (c == ChUnder);
  endfunction

  function automatic logic is_v6_byte(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)) ||
           is_digit(c) || (c == ChColon) || (c == ChDot);
  endfunction

endpackage

// File: rtl/core/uap_if.sv
// Valid/ready channel interfaces for authority bytes in and parse results out.
// Depends on uap_pkg for the payload structs.
interface uap_in_if;
  logic                valid;
  logic                ready;
  uap_pkg::auth_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uap_out_if;
  logic                  valid;
  logic                  ready;
  uap_pkg::auth_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/url_authority_parser.sv
// URL authority parser: checks host[:port] one byte per beat and streams host bytes.
// Depends on uap_pkg and the channel interfaces in uap_if.sv.

// Every input beat gives exactly one result beat, registered into the two-entry
// output buffer when it is taken. The parser takes one byte per cycle while the
// buffer's skid entry is empty: the byte is classified and the running state
// (phase, host count, port value, reject flag) updated combinationally, so a new
// byte is still taken while an earlier result waits on a stalled sink.
// Intermediate results carry the host byte when it joins the host; the result of
// the beat with last_byte set carries the verdict, the host length and the port.
// After that beat the parser is back at the start of an authority. The capacity
// register is written with cfg_we and may only change while the block is idle.
module url_authority_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [uap_pkg::CapWidth-1:0]  cfg_data,
  uap_in_if.sink                        chars,
  uap_out_if.source                     results
);
  import uap_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_REG,
    PH_V6,
    PH_AFTER_V6,
    PH_PORT_START,
    PH_PORT_DIGITS
  } phase_t;

  logic [CapWidth-1:0]   host_capacity;
  phase_t                phase, phase_next;
  logic [PortWidth-1:0]  port_accum, port_accum_next;
  logic [CountWidth-1:0] host_count, host_count_next;
  logic                  reject_flag, reject_next;

  logic                  accept;
  logic                  take;
  logic [CapWidth-1:0]   eff_cap;
  logic [19:0]           port_prod;
  logic                  bad;
  auth_item_t            item;
  auth_result_t          res;

  auth_result_t          out_data, skid_data;
  logic                  out_valid, skid_valid;

  assign item    = chars.data;
  assign accept  = chars.valid && chars.ready;
  assign eff_cap = (host_capacity > MaxHost) ? MaxHost : host_capacity;
  assign port_prod = {1'b0, port_accum, 3'b000} + {3'b000, port_accum, 1'b0} +
                     {16'd0, item.in_byte[3:0] - ChZero[3:0]};

  always_comb begin
    phase_next      = phase;
    port_accum_next = port_accum;
    host_count_next = host_count;
    reject_next     = reject_flag;
    take            = 1'b0;
    if (item.has_byte && !reject_flag) begin
      if (item.in_byte == ChAt) begin
        reject_next = 1'b1;
      end else begin
        case (phase)
          PH_START, PH_REG: begin
            if (phase == PH_START && item.in_byte == ChLBrack) begin
              phase_next = PH_V6;
            end else if (item.in_byte == ChColon) begin
              phase_next = PH_PORT_START;
            end else if (is_reg_byte(item.in_byte)) begin
              phase_next = PH_REG;
              take       = 1'b1;
            end else begin
              reject_next = 1'b1;
            end
          end
          PH_V6: begin
            if (item.in_byte == ChRBrack) begin
              if (host_count == '0) begin
                reject_next = 1'b1;
              end else begin
                phase_next = PH_AFTER_V6;
              end
            end else if (is_v6_byte(item.in_byte)) begin
              take = 1'b1;
            end else begin
              reject_next = 1'b1;
            end
          end
          PH_AFTER_V6: begin
            if (item.in_byte == ChColon) begin
              phase_next = PH_PORT_START;
            end else begin
              reject_next = 1'b1;
            end
          end
          PH_PORT_START, PH_PORT_DIGITS: begin
            if (is_digit(item.in_byte) && port_prod <= {4'd0, PortMax}) begin
              port_accum_next = port_prod[PortWidth-1:0];
              phase_next      = PH_PORT_DIGITS;
            end else begin
              reject_next = 1'b1;
            end
          end
          default: begin
            reject_next = 1'b1;
          end
        endcase
      end
    end

    // A host byte that would leave no room for the terminator rejects.
    if (take) begin
      if (({1'b0, host_count} + 9'd1) >= eff_cap) begin
        take        = 1'b0;
        reject_next = 1'b1;
      end else begin
        host_count_next = host_count + 8'd1;
      end
    end

    bad = reject_next || ({1'b0, host_count_next} >= eff_cap) ||
          (phase_next == PH_V6) || (phase_next == PH_PORT_START) ||
          ((phase_next == PH_PORT_DIGITS) && (port_accum_next == '0));

    res                 = '0;
    res.host_byte       = take ? item.in_byte : 8'd0;
    res.host_byte_valid = take;
    res.final_result    = item.last_byte;
    if (item.last_byte) begin
      res.status = bad;
      if (!bad) begin
        res.host_length = host_count_next;
        if (phase_next == PH_PORT_DIGITS) begin
          res.port_value   = port_accum_next;
          res.port_present = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_capacity <= CapReset;
    end else if (cfg_we) begin
      host_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      port_accum  <= '0;
      host_count  <= '0;
      reject_flag <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        phase       <= PH_START;
        port_accum  <= '0;
        host_count  <= '0;
        reject_flag <= 1'b0;
      end else begin
        phase       <= phase_next;
        port_accum  <= port_accum_next;
        host_count  <= host_count_next;
        reject_flag <= reject_next;
      end
    end
  end

  // Two-entry output buffer: the skid entry catches a beat that arrives while
  // the head result is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign chars.ready   = !skid_valid;
  assign results.valid = out_valid;
  assign results.data  = out_data;

`ifndef NO_ASSERTIONS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a beat while the head is empty");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last_byte) |=>
      (phase == PH_START && host_count == '0 && port_accum == '0 && !reject_flag))
    else $error("parser state not cleared after the last beat");

  a_status_only_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status || out_data.port_present)) |-> out_data.final_result)
    else $error("verdict fields set on a result that is not final");

  a_port_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.port_present) |->
      (!out_data.status && out_data.port_value != '0))
    else $error("port reported on a rejected authority or as zero");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !results.ready) |=> skid_valid)
    else $error("beat taken during a stall was not kept");
`endif

endmodule
